// File: rtl/hrxt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrxt_pkg
// Shared types, constants and lookup tables for the boot keyboard report to
// XT key event converter.
// ----------------------------------------------------------------------------
package hrxt_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int MOD_BITS    = 8;
    localparam int USAGE_COUNT = 149;
    localparam int IDX_W       = 3;

    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(KEY_SLOTS - 1);
    localparam logic [IDX_W-1:0] MOD_LAST  = IDX_W'(MOD_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_NEW,
        PH_OLD,
        PH_MOD
    } phase_t;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

    // bit 7 extended, bits 6..0 make code, zero means no mapping
    localparam logic [7:0] USAGE_TABLE [USAGE_COUNT] = '{
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32,
        8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11,
        8'h2D, 8'h15, 8'h2C,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39,
        8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33,
        8'h34, 8'h35,
        8'h3A,
        8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
        8'h57, 8'h58,
        8'h00, 8'h46, 8'h00, 8'hD2,
        8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1, 8'hCD, 8'hCB, 8'hD0, 8'hC8,
        8'h45,
        8'hB5, 8'h37, 8'h4A, 8'h4E, 8'h9C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C,
        8'h4D, 8'h47, 8'h48,
        8'h49, 8'h52, 8'h53,
        8'h56, 8'h00, 8'h00, 8'h59,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h7E, 8'h00,
        8'h73, 8'h70, 8'h7D, 8'h79, 8'h7B, 8'h5C,
        8'h00, 8'h00, 8'h00,
        8'h72, 8'h71, 8'h78, 8'h77, 8'h76
    };

    localparam logic [7:0] MOD_TABLE [MOD_BITS] = '{
        8'h1D, 8'h2A, 8'h38, 8'h00, 8'h9D, 8'h36, 8'hB8, 8'h00
    };

    function automatic logic [7:0] usage_lookup(input logic [7:0] usage);
        logic [7:0] entry;
        entry = 8'h00;
        if (usage < 8'(USAGE_COUNT)) begin
            entry = USAGE_TABLE[usage];
        end
        return entry;
    endfunction

endpackage
`default_nettype wire

// File: rtl/hrxt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrxt_ctrl
// Sequencer: takes a report, walks the candidate scan one step per cycle while
// not stalled, flushes any held event as the final beat and commits the report.
// ----------------------------------------------------------------------------
module hrxt_ctrl
    import hrxt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  dp_stat_t       stat,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // hold while a new hit would displace a held event into a full output
                if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
                    cmd.step = 1'b1;
                    if (stat.scan_end) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/hrxt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrxt_dp
// Datapath: report and kept-report registers, candidate selection and table
// lookup, one-event lookahead register and output beat register.
// ----------------------------------------------------------------------------
module hrxt_dp
    import hrxt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  ctrl_cmd_t       cmd,
    output dp_stat_t        stat,
    input  wire logic [7:0] in_mods,
    input  wire logic [7:0] in_keys [KEY_SLOTS],
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_scan_code,
    output logic            m_extended_key,
    output logic            m_key_pressed,
    output logic            m_last_event
);

    logic [7:0]       now_reg  [KEY_SLOTS];
    logic [7:0]       prev_reg [KEY_SLOTS];
    logic [7:0]       mods_reg;
    logic [7:0]       prev_mods_reg;
    phase_t           phase_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_entry_reg;
    logic             pend_press_reg;
    logic             out_valid_reg;
    logic [7:0]       out_entry_reg;
    logic             out_press_reg;
    logic             out_last_reg;

    logic [KEY_SLOTS-1:0] now_live;
    logic [KEY_SLOTS-1:0] prev_live;
    logic [7:0]           cand_usage;
    logic                 cand_active;
    logic                 cand_held;
    logic [7:0]           cand_entry;
    logic                 cand_press;
    logic                 cand_hit;
    logic                 out_free;
    logic                 out_load;

    always_comb begin
        now_live[0]  = (now_reg[0] != 8'h00);
        prev_live[0] = (prev_reg[0] != 8'h00);
        for (int i = 1; i < KEY_SLOTS; i++) begin
            now_live[i]  = now_live[i-1] && (now_reg[i] != 8'h00);
            prev_live[i] = prev_live[i-1] && (prev_reg[i] != 8'h00);
        end
    end

    always_comb begin
        cand_usage  = 8'h00;
        cand_active = 1'b0;
        cand_held   = 1'b0;
        cand_entry  = 8'h00;
        cand_press  = 1'b0;
        case (phase_reg)
            PH_NEW: begin
                cand_usage  = now_reg[idx_reg];
                cand_active = now_live[idx_reg];
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    if (prev_live[j] && (prev_reg[j] == cand_usage)) begin
                        cand_held = 1'b1;
                    end
                end
                cand_entry = usage_lookup(cand_usage);
                cand_press = 1'b1;
            end
            PH_OLD: begin
                cand_usage  = prev_reg[idx_reg];
                cand_active = prev_live[idx_reg];
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    if (now_live[j] && (now_reg[j] == cand_usage)) begin
                        cand_held = 1'b1;
                    end
                end
                cand_entry = usage_lookup(cand_usage);
                cand_press = 1'b0;
            end
            PH_MOD: begin
                cand_active = mods_reg[idx_reg] ^ prev_mods_reg[idx_reg];
                cand_entry  = MOD_TABLE[idx_reg];
                cand_press  = mods_reg[idx_reg];
            end
            default: begin
                cand_active = 1'b0;
            end
        endcase
        cand_hit = cand_active && !cand_held && (cand_entry != 8'h00);
    end

    assign out_free        = !out_valid_reg || m_ready;
    assign out_load        = (cmd.step && cand_hit && pend_valid_reg) || cmd.flush;
    assign stat.hit        = cand_hit;
    assign stat.scan_end   = (phase_reg == PH_MOD) && (idx_reg == MOD_LAST);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                prev_reg[i] <= 8'h00;
            end
            prev_mods_reg  <= 8'h00;
            phase_reg      <= PH_NEW;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                phase_reg      <= PH_NEW;
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.step) begin
                if (cand_hit) begin
                    pend_valid_reg <= 1'b1;
                end
                if ((phase_reg != PH_MOD) && (idx_reg == SLOT_LAST)) begin
                    phase_reg <= (phase_reg == PH_NEW) ? PH_OLD : PH_MOD;
                    idx_reg   <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    prev_reg[i] <= now_reg[i];
                end
                prev_mods_reg <= mods_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                now_reg[i] <= in_keys[i];
            end
            mods_reg <= in_mods;
        end
        if (cmd.step && cand_hit) begin
            pend_entry_reg <= cand_entry;
            pend_press_reg <= cand_press;
            if (pend_valid_reg) begin
                out_entry_reg <= pend_entry_reg;
                out_press_reg <= pend_press_reg;
                out_last_reg  <= 1'b0;
            end
        end
        if (cmd.flush) begin
            out_entry_reg <= pend_entry_reg;
            out_press_reg <= pend_press_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_scan_code    = out_entry_reg[6:0];
    assign m_extended_key = out_entry_reg[7];
    assign m_key_pressed  = out_press_reg;
    assign m_last_event   = out_last_reg;

endmodule
`default_nettype wire

// File: rtl/hid_report_to_xt_key_events_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hid_report_to_xt_key_events_core
// Converts USB boot keyboard reports into XT set-1 key event beats.
// ----------------------------------------------------------------------------
// One report is taken at a time. After it is accepted the block steps over
// 20 candidates, one per cycle (6 new slots, 6 kept slots, 8 modifier bits)
// unless a new event finds the output still full, then flushes the last event
// and stores the report before it takes the next one. Each beat is a press or
// release of one key; the last beat of a report carries m_last_event. A
// report that changes nothing gives no beat.
// ----------------------------------------------------------------------------
module hid_report_to_xt_key_events_core
    import hrxt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_modifier_bits,
    input  wire logic [7:0] s_key_slot_0,
    input  wire logic [7:0] s_key_slot_1,
    input  wire logic [7:0] s_key_slot_2,
    input  wire logic [7:0] s_key_slot_3,
    input  wire logic [7:0] s_key_slot_4,
    input  wire logic [7:0] s_key_slot_5,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_scan_code,
    output logic            m_extended_key,
    output logic            m_key_pressed,
    output logic            m_last_event
);

    ctrl_cmd_t  cmd;
    dp_stat_t   stat;
    logic [7:0] in_keys [KEY_SLOTS];

    assign in_keys[0] = s_key_slot_0;
    assign in_keys[1] = s_key_slot_1;
    assign in_keys[2] = s_key_slot_2;
    assign in_keys[3] = s_key_slot_3;
    assign in_keys[4] = s_key_slot_4;
    assign in_keys[5] = s_key_slot_5;

    hrxt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hrxt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_mods        (s_modifier_bits),
        .in_keys        (in_keys),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scan_code    (m_scan_code),
        .m_extended_key (m_extended_key),
        .m_key_pressed  (m_key_pressed),
        .m_last_event   (m_last_event)
    );

endmodule
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the boot keyboard report to XT key event converter. A short table
// of reports walks the corner cases (empty slots, unmapped usages, repeated
// usages, unchanged reports, GUI-only modifier changes, the full 18-event
// report); a run of random typing follows. Every accepted report is run
// through an in-bench predictor and each event beat is compared field by
// field. Sender bursts and receiver stalls are random, with one long
// receiver hold-off and one pause that lets the output drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = hrxt_pkg::KEY_SLOTS;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0]                       mods;
        logic [0:SLOT_COUNT-1][7:0]       keys;
    } report_t;

    typedef struct packed {
        logic [6:0] scan_code;
        logic       extended_key;
        logic       key_pressed;
        logic       last_event;
    } key_event_t;

    typedef struct packed {
        report_t              rpt;
        logic                 typed;
        logic [1:0]           n_typed;
        key_event_t [0:1]     typed_ev;
    } stim_row_t;

    localparam key_event_t NO_EVENT = '0;

    // bit 7 extended, bits 6..0 make code
    localparam logic [7:0] KEYMAP [0:148] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
        8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
        8'h00, 8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1, 8'hCD,
        8'hCB, 8'hD0, 8'hC8, 8'h45, 8'hB5, 8'h37, 8'h4A, 8'h4E,
        8'h9C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
        8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'h00, 8'h00, 8'h59,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h73,
        8'h70, 8'h7D, 8'h79, 8'h7B, 8'h5C, 8'h00, 8'h00, 8'h00,
        8'h72, 8'h71, 8'h78, 8'h77, 8'h76
    };

    localparam logic [7:0] MODMAP [0:7] = '{
        8'h1D, 8'h2A, 8'h38, 8'h00, 8'h9D, 8'h36, 8'hB8, 8'h00
    };

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_modifier_bits = 8'h00;
    logic [7:0] s_key_slot_0    = 8'h00;
    logic [7:0] s_key_slot_1    = 8'h00;
    logic [7:0] s_key_slot_2    = 8'h00;
    logic [7:0] s_key_slot_3    = 8'h00;
    logic [7:0] s_key_slot_4    = 8'h00;
    logic [7:0] s_key_slot_5    = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [6:0] m_scan_code;
    logic       m_extended_key;
    logic       m_key_pressed;
    logic       m_last_event;

    stim_row_t  cur_row = '0;
    key_event_t expected_events [$];
    key_event_t derived [$];
    logic [0:SLOT_COUNT-1][7:0] kept_keys = '0;
    logic [7:0] kept_mods       = 8'h00;
    logic [7:0] fingers [$];
    logic [7:0] typing_mods     = 8'h00;
    report_t    last_typing     = '0;
    int         error_count     = 0;
    int         cycle_count     = 0;
    int         burst_left      = 0;
    bit         valid_dropped   = 1'b1;
    bit         hold_off_req    = 1'b0;
    int         hold_left       = 0;
    int         stall_mode      = 0;
    int         stall_left      = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    hid_report_to_xt_key_events_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_modifier_bits (s_modifier_bits),
        .s_key_slot_0    (s_key_slot_0),
        .s_key_slot_1    (s_key_slot_1),
        .s_key_slot_2    (s_key_slot_2),
        .s_key_slot_3    (s_key_slot_3),
        .s_key_slot_4    (s_key_slot_4),
        .s_key_slot_5    (s_key_slot_5),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scan_code     (m_scan_code),
        .m_extended_key  (m_extended_key),
        .m_key_pressed   (m_key_pressed),
        .m_last_event    (m_last_event)
    );

    function automatic key_event_t xt_event(input logic [6:0] code, input logic ext,
                                            input logic press, input logic final_beat);
        key_event_t ev;
        ev.scan_code    = code;
        ev.extended_key = ext;
        ev.key_pressed  = press;
        ev.last_event   = final_beat;
        return ev;
    endfunction

    function automatic stim_row_t stim_row(input logic [7:0] mods, input logic [47:0] keys,
                                           input int n_typed, input key_event_t e0,
                                           input key_event_t e1);
        stim_row_t row;
        row.rpt.mods    = mods;
        row.rpt.keys    = keys;
        row.typed       = (n_typed >= 0);
        row.n_typed     = (n_typed >= 0) ? 2'(n_typed) : 2'd0;
        row.typed_ev[0] = e0;
        row.typed_ev[1] = e1;
        return row;
    endfunction

    function automatic logic [7:0] xt_entry(input logic [7:0] usage);
        return (usage < 8'd149) ? KEYMAP[usage] : 8'h00;
    endfunction

    function automatic bit slot_holds(input logic [0:SLOT_COUNT-1][7:0] slots,
                                      input logic [7:0] usage);
        bit open;
        bit found;
        open  = 1'b1;
        found = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (slots[j] == 8'h00) open = 1'b0;
            if (open && slots[j] == usage) found = 1'b1;
        end
        return found;
    endfunction

    // presses of new keys, releases of gone keys, then modifier changes
    function automatic void derive_key_events(input report_t rpt);
        logic [7:0] entry;
        logic [7:0] changed;
        bit         scanning;
        key_event_t ev;
        derived.delete();
        scanning = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (rpt.keys[i] == 8'h00) scanning = 1'b0;
            entry = xt_entry(rpt.keys[i]);
            if (scanning && entry != 8'h00 && !slot_holds(kept_keys, rpt.keys[i]))
                derived.push_back(xt_event(entry[6:0], entry[7], 1'b1, 1'b0));
        end
        scanning = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (kept_keys[i] == 8'h00) scanning = 1'b0;
            entry = xt_entry(kept_keys[i]);
            if (scanning && entry != 8'h00 && !slot_holds(rpt.keys, kept_keys[i]))
                derived.push_back(xt_event(entry[6:0], entry[7], 1'b0, 1'b0));
        end
        changed = kept_mods ^ rpt.mods;
        for (int i = 0; i < 8; i++) begin
            if (MODMAP[i] != 8'h00 && changed[i])
                derived.push_back(xt_event(MODMAP[i][6:0], MODMAP[i][7], rpt.mods[i], 1'b0));
        end
        if (derived.size() > 0) begin
            ev = derived.pop_back();
            ev.last_event = 1'b1;
            derived.push_back(ev);
        end
        kept_keys = rpt.keys;
        kept_mods = rpt.mods;
    endfunction

    // mostly plausible typing: keys go down and up, slots packed from the front
    function automatic report_t next_typing_report();
        report_t    r;
        int         pick;
        int         idx;
        bit         dup;
        logic [7:0] u;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            r.mods = 8'($urandom);
            r.keys = 48'({$urandom, $urandom});
        end else if (pick < 20) begin
            r = last_typing;
        end else begin
            repeat ($urandom_range(1, 3)) begin
                if (fingers.size() < SLOT_COUNT &&
                    (fingers.size() == 0 || $urandom_range(0, 1) == 1)) begin
                    u = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(4, 148));
                    dup = (u == 8'h00);
                    foreach (fingers[j]) if (fingers[j] == u) dup = 1'b1;
                    if (!dup) fingers.push_back(u);
                end else begin
                    fingers.delete($urandom_range(0, fingers.size() - 1));
                end
            end
            if ($urandom_range(0, 2) == 0) typing_mods ^= 8'(1 << $urandom_range(0, 7));
            r.mods = typing_mods;
            r.keys = '0;
            foreach (fingers[j]) r.keys[j] = fingers[j];
            if (pick < 30) begin
                case ($urandom_range(0, 2))
                    0: begin
                        idx = $urandom_range(0, 4);
                        r.keys[idx] = 8'h00;
                    end
                    1: begin
                        idx = $urandom_range(1, 5);
                        r.keys[idx] = r.keys[0];
                    end
                    default: begin
                        idx = $urandom_range(0, 5);
                        r.keys[idx] = 8'($urandom_range(149, 255));
                    end
                endcase
            end
        end
        last_typing = r;
        return r;
    endfunction

    // entered at a falling edge, leaves at a falling edge
    task automatic send_item(input stim_row_t row, input bit hold_after, input bit pause_after);
        int gap;
        s_valid         <= 1'b1;
        s_modifier_bits <= row.rpt.mods;
        s_key_slot_0    <= row.rpt.keys[0];
        s_key_slot_1    <= row.rpt.keys[1];
        s_key_slot_2    <= row.rpt.keys[2];
        s_key_slot_3    <= row.rpt.keys[3];
        s_key_slot_4    <= row.rpt.keys[4];
        s_key_slot_5    <= row.rpt.keys[5];
        cur_row         <= row;
        valid_dropped    = 1'b0;
        do @(posedge aclk); while (!s_ready);
        if (hold_after) hold_off_req = 1'b1;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 10);
        end
        if (gap > 0 || pause_after) begin
            s_valid      <= 1'b0;
            valid_dropped = 1'b1;
            repeat (gap) @(negedge aclk);
            if (pause_after) begin
                do @(negedge aclk); while (expected_events.size() != 0);
            end
        end
    endtask

    always @(posedge aclk) begin : key_event_check
        key_event_t want;
        report_t    seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen = {s_modifier_bits, s_key_slot_0, s_key_slot_1, s_key_slot_2,
                        s_key_slot_3, s_key_slot_4, s_key_slot_5};
                derive_key_events(seen);
                if (cur_row.typed) begin
                    for (int k = 0; k < int'(cur_row.n_typed); k++)
                        expected_events.push_back(cur_row.typed_ev[k]);
                end else begin
                    foreach (derived[k]) expected_events.push_back(derived[k]);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected beat: scan_code %0h pressed %0b",
                           m_scan_code, m_key_pressed);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_scan_code !== want.scan_code) begin
                        $error("scan_code: expected %0h, got %0h", want.scan_code, m_scan_code);
                        error_count++;
                    end
                    if (m_extended_key !== want.extended_key) begin
                        $error("extended_key: expected %0b, got %0b",
                               want.extended_key, m_extended_key);
                        error_count++;
                    end
                    if (m_key_pressed !== want.key_pressed) begin
                        $error("key_pressed: expected %0b, got %0b",
                               want.key_pressed, m_key_pressed);
                        error_count++;
                    end
                    if (m_last_event !== want.last_event) begin
                        $error("last_event: expected %0b, got %0b",
                               want.last_event, m_last_event);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin : receiver_stall
        bit take;
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       take = 1'b1;
            1:       take = ($urandom_range(0, 3) != 0);
            2:       take = ($urandom_range(0, 1) == 1);
            default: take = ($urandom_range(0, 4) == 0);
        endcase
        m_ready <= take && (hold_left == 0);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout with %0d beats outstanding", expected_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t plan [$];
        report_t   rpt;
        int        hold_at;
        int        pause_at;
        plan.push_back(stim_row(8'h00, 48'h00_00_00_00_00_00, 0, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h04_00_00_00_00_00, 1,
                                xt_event(7'h1E, 1'b0, 1'b1, 1'b1), NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h04_00_00_00_00_00, 0, NO_EVENT, NO_EVENT));
        // empty slot 0 hides the key behind it
        plan.push_back(stim_row(8'h00, 48'h00_04_00_00_00_00, 1,
                                xt_event(7'h1E, 1'b0, 1'b0, 1'b1), NO_EVENT));
        plan.push_back(stim_row(8'hFF, 48'h00_00_00_00_00_00, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h88, 48'h00_00_00_00_00_00, -1, NO_EVENT, NO_EVENT));
        // GUI bits alone
        plan.push_back(stim_row(8'h00, 48'h00_00_00_00_00_00, 0, NO_EVENT, NO_EVENT));
        // unmapped usages, pressed and then released
        plan.push_back(stim_row(8'h00, 48'hFF_95_01_46_00_00, 0, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h00_00_00_00_00_00, 0, NO_EVENT, NO_EVENT));
        // same usage in two slots
        plan.push_back(stim_row(8'h00, 48'h04_04_00_00_00_00, 2,
                                xt_event(7'h1E, 1'b0, 1'b1, 1'b0),
                                xt_event(7'h1E, 1'b0, 1'b1, 1'b1)));
        plan.push_back(stim_row(8'h00, 48'h04_00_00_00_00_00, 0, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h00_00_00_00_00_00, 1,
                                xt_event(7'h1E, 1'b0, 1'b0, 1'b1), NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h52_58_E0_65_87_94, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h04_05_06_07_08_09, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h77, 48'h0A_0B_0C_0D_0E_0F, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'hFF, 48'hFF_FF_FF_FF_FF_FF, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h80_40_20_10_08_01, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h11, 48'h39_53_47_49_4A_4B, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h49_00_04_05_00_00, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h22, 48'h00_00_00_00_00_00, -1, NO_EVENT, NO_EVENT));
        plan.push_back(stim_row(8'h00, 48'h00_00_00_00_00_00, -1, NO_EVENT, NO_EVENT));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[k]) send_item(plan[k], 1'b0, 1'b0);

        hold_at  = $urandom_range(60, 140);
        pause_at = $urandom_range(220, 320);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            rpt = next_typing_report();
            send_item(stim_row(rpt.mods, rpt.keys, -1, NO_EVENT, NO_EVENT),
                      k == hold_at, k == pause_at);
        end

        if (!valid_dropped) s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_events.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
